// ===== sv/pcc_pkg.sv =====
// Shared types and constants of the polyline corner-cut smoother.
package pcc_pkg;

  localparam int MAX_PASSES  = 2;
  localparam int COORD_WIDTH = 32;

  // Segment length codes held by each cell.
  localparam logic [1:0] SEG_NONE = 2'd0;
  localparam logic [1:0] SEG_ONE  = 2'd1;
  localparam logic [1:0] SEG_MANY = 2'd2;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  // A token on the internal chain is either a point or the end-of-item marker.
  typedef enum logic {
    TK_POINT = 1'b0,
    TK_EOI   = 1'b1
  } tok_kind_t;

  typedef struct packed {
    tok_kind_t kind;
    logic      end_trail;
    coord_t    x;
    coord_t    y;
    coord_t    z;
  } tok_t;

endpackage

// ===== sv/pcc_if.sv =====
// Stream interfaces for the point input and the smoothed point output.
interface pcc_in_if import pcc_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t pos_x;
  coord_t pos_y;
  coord_t pos_z;
  logic   end_of_trail;

  modport source (output valid, output pos_x, output pos_y, output pos_z,
                  output end_of_trail, input ready);
  modport sink (input valid, input pos_x, input pos_y, input pos_z,
                input end_of_trail, output ready);
endinterface

interface pcc_out_if import pcc_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t out_x;
  coord_t out_y;
  coord_t out_z;
  logic   trail_done;
  logic   last_of_run;

  modport source (output valid, output out_x, output out_y, output out_z,
                  output trail_done, output last_of_run, input ready);
  modport sink (input valid, input out_x, input out_y, input out_z,
                input trail_done, input last_of_run, output ready);
endinterface

// ===== sv/pcc_cell.sv =====
// One corner-cutting pass: holds its previous point and segment length.
module pcc_cell import pcc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic on,
  input  logic in_valid,
  output logic in_ready,
  input  tok_t in_tok,
  output logic out_valid,
  input  logic out_ready,
  output tok_t out_tok
);

  function automatic coord_t cut(input coord_t a, input coord_t b);
    logic signed [COORD_WIDTH+1:0] s;
    s = {{2{a[COORD_WIDTH-1]}}, a} + {a[COORD_WIDTH-1], a, 1'b0} + {{2{b[COORD_WIDTH-1]}}, b};
    return s[COORD_WIDTH+1:2];
  endfunction

  tok_t       cur;
  logic       cur_valid;
  logic       phase;
  logic [1:0] seg;
  coord_t     prev_x;
  coord_t     prev_y;
  coord_t     prev_z;

  logic   is_break;
  logic   two;
  logic   use_cut;
  logic   out_free;
  logic   fire;
  logic   done;
  tok_t   prev_tok;
  tok_t   e0;
  tok_t   e1;
  tok_t   emit_tok;
  tok_t   cut_tok;
  coord_t ax, ay, az, bx, by, bz;

  always_comb begin
    is_break = (cur.kind == TK_POINT) && (cur.x == '0) && (cur.y == '0) && (cur.z == '0);
    prev_tok = cur;
    prev_tok.kind = TK_POINT;
    prev_tok.x = prev_x;
    prev_tok.y = prev_y;
    prev_tok.z = prev_z;

    // One shared cutter: first output weights the old point, second the new.
    ax = phase ? cur.x : prev_x;
    ay = phase ? cur.y : prev_y;
    az = phase ? cur.z : prev_z;
    bx = phase ? prev_x : cur.x;
    by = phase ? prev_y : cur.y;
    bz = phase ? prev_z : cur.z;
    cut_tok = cur;
    cut_tok.x = cut(ax, bx);
    cut_tok.y = cut(ay, by);
    cut_tok.z = cut(az, bz);

    two     = 1'b0;
    use_cut = 1'b0;
    e0      = cur;
    e1      = cur;
    if (on) begin
      if (cur.kind == TK_EOI) begin
        two = cur.end_trail && (seg == SEG_MANY);
        e0  = two ? prev_tok : cur;
      end else if (is_break) begin
        two = (seg == SEG_MANY);
        e0  = two ? prev_tok : cur;
      end else if (seg != SEG_NONE) begin
        two     = 1'b1;
        use_cut = 1'b1;
      end
    end
    emit_tok = use_cut ? cut_tok : (phase ? e1 : e0);

    out_free = !out_valid || out_ready;
    fire     = cur_valid && out_free;
    done     = fire && (phase || !two);
    in_ready = !cur_valid || done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      phase     <= 1'b0;
      seg       <= SEG_NONE;
      out_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        cur_valid <= 1'b1;
      end else if (done) begin
        cur_valid <= 1'b0;
      end
      if (fire) begin
        phase <= !done;
      end
      if (done) begin
        if (cur.kind == TK_EOI) begin
          if (cur.end_trail) begin
            seg <= SEG_NONE;
          end
        end else if (on) begin
          if (is_break) begin
            seg <= SEG_NONE;
          end else begin
            seg <= (seg == SEG_NONE) ? SEG_ONE : SEG_MANY;
          end
        end
      end
      if (fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cur <= in_tok;
    end
    if (done && on && (cur.kind == TK_POINT) && !is_break) begin
      prev_x <= cur.x;
      prev_y <= cur.y;
      prev_z <= cur.z;
    end
    if (fire) begin
      out_tok <= emit_tok;
    end
  end

endmodule

// ===== sv/pcc_collect.sv =====
// Output stage: holds one point back so the item marker can flag it.
module pcc_collect import pcc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  tok_t       in_tok,
  pcc_out_if.source  pts_out
);

  logic   held_valid;
  coord_t held_x;
  coord_t held_y;
  coord_t held_z;
  logic   out_valid;

  logic out_free;
  logic take;
  logic release_held;

  assign pts_out.valid = out_valid;

  always_comb begin
    out_free     = !out_valid || pts_out.ready;
    in_ready     = (in_tok.kind == TK_EOI) ? out_free : (!held_valid || out_free);
    take         = in_valid && in_ready;
    release_held = take && held_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (take) begin
        held_valid <= (in_tok.kind == TK_POINT);
      end
      if (release_held) begin
        out_valid <= 1'b1;
      end else if (pts_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && (in_tok.kind == TK_POINT)) begin
      held_x <= in_tok.x;
      held_y <= in_tok.y;
      held_z <= in_tok.z;
    end
    if (release_held) begin
      pts_out.out_x       <= held_x;
      pts_out.out_y       <= held_y;
      pts_out.out_z       <= held_z;
      pts_out.last_of_run <= (in_tok.kind == TK_EOI);
      pts_out.trail_done  <= (in_tok.kind == TK_EOI) && in_tok.end_trail;
    end
  end

endmodule

// ===== sv/polyline_corner_cut_smoother_unit.sv =====
// Top level of the polyline corner-cut smoother: input stage, pass chain, output stage.
//
// Points enter on pts_in (valid/ready); a transaction takes place at a rising
// edge where both are high. Smoothed points leave on pts_out in the same way,
// each carrying last_of_run on the final result of its input point and
// trail_done when that point also closed the trail. The pass count is written
// through cfg_wr_en and cfg_wr_data; zero is treated as one pass, three as two.
// Each input point is turned into a point token followed by an end-of-item
// token. Every pass is one cell of the chain and moves one token per cycle
// while its output is not stalled, and emits the two results of a token that
// yields two one after the other. The busiest cell sets the rate. The output
// stage holds each point back until the next token arrives; the last result
// of an item is released when the end-of-item token reaches the output stage.
// Synchronous reset empties every stage, clears the segment state of all
// passes and sets the pass count to one. pts_in.ready is low for at least the
// cycle after each transaction, while the input stage still owes the chain
// its point or marker. When the receiver stalls, the output register holds
// its transaction, the chain backs up stage by stage, and pts_in.ready stays
// low once every stage is full.
module polyline_corner_cut_smoother_unit import pcc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  pcc_in_if.sink     pts_in,
  pcc_out_if.source  pts_out,
  input  logic       cfg_wr_en,
  input  logic [1:0] cfg_wr_data
);

  // Pass count register; bit one alone tells two passes from one after clamping.
  logic [1:0] passes;
  logic       two_pass;

  always_ff @(posedge clk) begin
    if (rst) begin
      passes <= 2'd1;
    end else if (cfg_wr_en) begin
      passes <= cfg_wr_data;
    end
  end

  assign two_pass = passes[1];

  // Input stage: hands the point to the first cell, then the end-of-item marker.
  logic   inj_valid;
  logic   inj_eoi;
  logic   inj_end;
  coord_t inj_x;
  coord_t inj_y;
  coord_t inj_z;
  logic   inj_taken;
  logic   inj_done;
  logic   in_take;

  logic                  link_valid [MAX_PASSES+1];
  logic                  link_ready [MAX_PASSES+1];
  tok_t                  link_tok   [MAX_PASSES+1];
  logic [MAX_PASSES-1:0] cell_on;

  always_comb begin
    inj_taken    = inj_valid && link_ready[0];
    inj_done     = inj_taken && inj_eoi;
    pts_in.ready = !inj_valid || inj_done;
    in_take      = pts_in.valid && pts_in.ready;

    link_valid[0]          = inj_valid;
    link_tok[0].kind       = inj_eoi ? TK_EOI : TK_POINT;
    link_tok[0].end_trail  = inj_end;
    link_tok[0].x          = inj_x;
    link_tok[0].y          = inj_y;
    link_tok[0].z          = inj_z;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inj_valid <= 1'b0;
      inj_eoi   <= 1'b0;
    end else begin
      if (in_take) begin
        inj_valid <= 1'b1;
        inj_eoi   <= 1'b0;
      end else if (inj_done) begin
        inj_valid <= 1'b0;
      end else if (inj_taken) begin
        inj_eoi <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      inj_x   <= pts_in.pos_x;
      inj_y   <= pts_in.pos_y;
      inj_z   <= pts_in.pos_z;
      inj_end <= pts_in.end_of_trail;
    end
  end

  // Chain of passes. A cell that is switched off forwards tokens untouched
  // and only clears its segment when the trail ends.
  for (genvar k = 0; k < MAX_PASSES; k++) begin : g_pass
    assign cell_on[k] = (k == 0) ? 1'b1 : ((k == 1) ? two_pass : 1'b0);

    pcc_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .on        (cell_on[k]),
      .in_valid  (link_valid[k]),
      .in_ready  (link_ready[k]),
      .in_tok    (link_tok[k]),
      .out_valid (link_valid[k+1]),
      .out_ready (link_ready[k+1]),
      .out_tok   (link_tok[k+1])
    );
  end

  pcc_collect u_collect (
    .clk      (clk),
    .rst      (rst),
    .in_valid (link_valid[MAX_PASSES]),
    .in_ready (link_ready[MAX_PASSES]),
    .in_tok   (link_tok[MAX_PASSES]),
    .pts_out  (pts_out)
  );

  // The end of the trail is only ever flagged on the final result of an item.
  assert property (@(posedge clk) disable iff (rst)
    pts_out.valid && pts_out.trail_done |-> pts_out.last_of_run)
    else $error("trail_done without last_of_run");

  // A newly taken point is always offered to the chain as a point token first.
  assert property (@(posedge clk) disable iff (rst)
    pts_in.valid && pts_in.ready |=> inj_valid && !inj_eoi)
    else $error("input stage did not start with the point token");

  // Nothing leaves the block in the cycle after reset.
  assert property (@(posedge clk)
    $past(rst) |-> !pts_out.valid && !inj_valid)
    else $error("output or input stage busy straight after reset");

endmodule

// ===== sim/polyline_corner_cut_smoother_unit_tb.sv =====
// Self-checking testbench for the polyline corner-cut smoother top level.
`timescale 1ns / 1ps

module polyline_corner_cut_smoother_unit_tb;
  import pcc_pkg::*;

  // One point of the trail. All three coordinates at zero form a break.
  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } pt_t;

  // One smoothed point as it should leave the block, with its two flags.
  typedef struct packed {
    pt_t  pt;
    logic trail_done;
    logic last_of_run;
  } smoothed_t;

  // How the random coordinates are spread over the signed range.
  typedef enum int {
    SPAN_FULL  = 0,
    SPAN_SMALL = 1,
    SPAN_EDGE  = 2
  } coord_span_t;

  localparam coord_t COORD_MIN     = coord_t'(32'h8000_0000);
  localparam coord_t COORD_MAX     = coord_t'(32'h7fff_ffff);
  localparam pt_t    BREAK_PT      = '0;
  localparam int     SETTLE_CYCLES = 16;   // generous cover of the chain latency
  localparam int     HOLD_CYCLES   = 200;  // length of the long output stall
  localparam int     RANDOM_ITEMS  = 185;

  logic       clk;
  logic       rst = 1'b1;
  logic       cfg_wr_en;
  logic [1:0] cfg_wr_data;

  pcc_in_if  in_bus ();
  pcc_out_if out_bus ();

  polyline_corner_cut_smoother_unit u_top (
    .clk         (clk),
    .rst         (rst),
    .pts_in      (in_bus),
    .pts_out     (out_bus),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // The testbench's own picture of the block: the pass count register and, per
  // pass, the last point accepted and how long the open segment is.
  logic [1:0] passes_reg;
  pt_t        last_pt [MAX_PASSES];
  logic [1:0] seg_len [MAX_PASSES];

  smoothed_t expected_pts [$];   // smoothed points still owed by the block
  pt_t       stage_pts [$];      // points leaving the pass now being worked out

  int items_sent;
  int results_seen;
  int error_count;
  bit tx_idle_en;
  bit rx_idle_en;
  bit hold_req;

  // --------------------------------------------------------------------------
  // Clock and time limit.
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // A run that has not finished by this point is declared hung.
  initial begin
    #1_000_000;
    $display("simulation failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Predictor.
  // --------------------------------------------------------------------------

  // Clamp the register to the one or two passes the block actually chains.
  function automatic int active_pass_count();
    if (passes_reg == 2'd0) return 1;
    if (passes_reg == 2'd3) return 2;
    return int'(passes_reg);
  endfunction

  // floor((3a + b) / 4), formed wide so that nothing overflows; the arithmetic
  // shift of a signed value rounds towards minus infinity.
  function automatic coord_t quarter_mix(coord_t a, coord_t b);
    longint sum;
    sum = 3 * longint'(a) + longint'(b);
    return coord_t'(sum >>> 2);
  endfunction

  function automatic pt_t cut_point(pt_t a, pt_t b);
    pt_t r;
    r.x = quarter_mix(a.x, b.x);
    r.y = quarter_mix(a.y, b.y);
    r.z = quarter_mix(a.z, b.z);
    return r;
  endfunction

  // Append one point to what the current pass emits.
  function automatic void stage_add(pt_t p);
    stage_pts = {stage_pts, p};
  endfunction

  // One point into pass k. A break closes the segment, re-emitting the last
  // point only when the segment held two or more, and then passes itself on.
  function automatic void pass_accept(int k, pt_t p);
    if (p == BREAK_PT) begin
      if (seg_len[k] == SEG_MANY) stage_add(last_pt[k]);
      seg_len[k] = SEG_NONE;
      stage_add(p);
      return;
    end
    if (seg_len[k] == SEG_NONE) begin
      stage_add(p);
      seg_len[k] = SEG_ONE;
    end else begin
      stage_add(cut_point(last_pt[k], p));
      stage_add(cut_point(p, last_pt[k]));
      seg_len[k] = SEG_MANY;
    end
    last_pt[k] = p;
  endfunction

  // End of the trail as seen by pass k.
  function automatic void pass_close(int k);
    if (seg_len[k] == SEG_MANY) stage_add(last_pt[k]);
    seg_len[k] = SEG_NONE;
  endfunction

  // Work out every smoothed point that one accepted input point causes. A
  // later pass only depends on the order of what the earlier pass emits, so
  // each pass can be run over the whole output of the one before it.
  function automatic void predict_point(pt_t p, bit eot);
    pt_t       feed_pts [$];
    smoothed_t r;
    int        n;
    n = active_pass_count();
    feed_pts = {p};
    for (int k = 0; k < n; k++) begin
      stage_pts.delete();
      foreach (feed_pts[i]) pass_accept(k, feed_pts[i]);
      if (eot) pass_close(k);
      feed_pts = stage_pts;
    end
    // The end of the trail clears every pass, the idle ones included.
    if (eot) begin
      foreach (seg_len[k]) seg_len[k] = SEG_NONE;
    end
    foreach (feed_pts[i]) begin
      r.pt          = feed_pts[i];
      r.last_of_run = (i == feed_pts.size() - 1);
      r.trail_done  = r.last_of_run && eot;
      expected_pts  = {expected_pts, r};
    end
  endfunction

  // --------------------------------------------------------------------------
  // Reporting and checking.
  // --------------------------------------------------------------------------
  task automatic report_mismatch(string msg);
    $display("MISMATCH at %0t ns: %s", $time, msg);
    error_count++;
  endtask

  // Every output transaction is matched against the oldest expectation.
  always @(posedge clk) begin : result_check
    smoothed_t want;
    if (!rst && out_bus.valid && out_bus.ready) begin
      results_seen++;
      if (expected_pts.size() == 0) begin
        report_mismatch($sformatf("result %0d (%h %h %h) arrived with none expected",
                                  results_seen, out_bus.out_x, out_bus.out_y,
                                  out_bus.out_z));
      end else begin
        want = expected_pts.pop_front();
        if (out_bus.out_x !== want.pt.x)
          report_mismatch($sformatf("result %0d out_x %h, expected %h",
                                    results_seen, out_bus.out_x, want.pt.x));
        if (out_bus.out_y !== want.pt.y)
          report_mismatch($sformatf("result %0d out_y %h, expected %h",
                                    results_seen, out_bus.out_y, want.pt.y));
        if (out_bus.out_z !== want.pt.z)
          report_mismatch($sformatf("result %0d out_z %h, expected %h",
                                    results_seen, out_bus.out_z, want.pt.z));
        if (out_bus.trail_done !== want.trail_done)
          report_mismatch($sformatf("result %0d trail_done %b, expected %b",
                                    results_seen, out_bus.trail_done, want.trail_done));
        if (out_bus.last_of_run !== want.last_of_run)
          report_mismatch($sformatf("result %0d last_of_run %b, expected %b",
                                    results_seen, out_bus.last_of_run, want.last_of_run));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver. Before each result it may first hold ready low; on request it also
  // holds off for a long stretch, which it counts itself, so that the pass chain
  // fills and the input side has to stall.
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int unsigned wait_cycles;
    out_bus.ready = 1'b0;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      wait_cycles = rx_idle_en ? $urandom_range(0, 8) : 0;
      if (hold_req) begin
        wait_cycles += HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (wait_cycles != 0) begin
        out_bus.ready <= 1'b0;
        repeat (wait_cycles) @(negedge clk);
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk); while (!out_bus.valid);
      @(negedge clk);
    end
  end

  // --------------------------------------------------------------------------
  // Sender and the shared helpers of the test tasks. Every helper starts and
  // ends on a falling edge. After a transaction valid stays high, so the next
  // call either offers a new point or lowers valid, never both in one step.
  // --------------------------------------------------------------------------
  task automatic send_point(pt_t p, bit eot);
    int unsigned gap;
    gap = tx_idle_en ? $urandom_range(0, 8) : 0;
    if (gap != 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_bus.valid        <= 1'b1;
    in_bus.pos_x        <= p.x;
    in_bus.pos_y        <= p.y;
    in_bus.pos_z        <= p.z;
    in_bus.end_of_trail <= eot;
    do @(posedge clk); while (!in_bus.ready);
    predict_point(p, eot);
    items_sent++;
    @(negedge clk);
  endtask

  // Stop offering points, wait for every owed result, then let the chain settle.
  task automatic wait_until_drained();
    in_bus.valid <= 1'b0;
    while (expected_pts.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // The register is only written with the block idle.
  task automatic set_passes(logic [1:0] value);
    wait_until_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    passes_reg  = value;
  endtask

  function automatic pt_t make_pt(coord_t x, coord_t y, coord_t z);
    pt_t p;
    p.x = x;
    p.y = y;
    p.z = z;
    return p;
  endfunction

  function automatic coord_t rand_coord(coord_span_t span);
    case (span)
      SPAN_SMALL: return coord_t'(int'($urandom_range(0, 16)) - 8);
      SPAN_EDGE: begin
        case ($urandom_range(0, 4))
          0: return COORD_MIN;
          1: return COORD_MAX;
          2: return coord_t'(-1);
          3: return coord_t'(1);
          default: return coord_t'(0);
        endcase
      end
      default: return coord_t'($urandom);
    endcase
  endfunction

  function automatic pt_t rand_pt(coord_span_t span);
    return make_pt(rand_coord(span), rand_coord(span), rand_coord(span));
  endfunction

  // --------------------------------------------------------------------------
  // Test tasks.
  // --------------------------------------------------------------------------

  // With one pass: a break with nothing open gives only itself, and a
  // one-point segment is not repeated when it closes at a break or at the end.
  task automatic test_breaks_and_single_points();
    set_passes(2'd1);
    send_point(BREAK_PT, 1'b0);
    send_point(make_pt(32'sd300, -32'sd300, 32'sd7), 1'b0);
    send_point(BREAK_PT, 1'b0);
    send_point(make_pt(-32'sd1, 32'sd2, -32'sd3), 1'b1);
    wait_until_drained();
  endtask

  // Full-scale coordinates and negative rounding, a segment closed by a break
  // and one closed by the end of the trail.
  task automatic test_extremes_one_pass();
    send_point(make_pt(COORD_MAX, COORD_MIN, -32'sd1), 1'b0);
    send_point(make_pt(COORD_MIN, COORD_MAX, 32'sd1), 1'b0);
    send_point(make_pt(-32'sd5, 32'sd3, -32'sd2), 1'b0);
    send_point(make_pt(32'sd7, -32'sd7, 32'sd6), 1'b0);
    send_point(BREAK_PT, 1'b0);
    send_point(make_pt(COORD_MAX, COORD_MAX, COORD_MAX), 1'b0);
    send_point(make_pt(COORD_MIN, COORD_MIN, COORD_MIN), 1'b1);
    wait_until_drained();
  endtask

  // Two passes. Cutting between (-1,-1,-1) and (1,1,1) yields an all-zero
  // point, which the second pass must take for a break.
  task automatic test_two_pass_zero_cut();
    set_passes(2'd2);
    send_point(make_pt(-32'sd1, -32'sd1, -32'sd1), 1'b0);
    send_point(make_pt(32'sd1, 32'sd1, 32'sd1), 1'b0);
    send_point(make_pt(32'sd256, -32'sd256, 32'sd512), 1'b0);
    send_point(BREAK_PT, 1'b0);
    send_point(make_pt(32'sd3, 32'sd2, 32'sd1), 1'b1);
    wait_until_drained();
  endtask

  // Zero must act as one pass and three as two; the second trail ends on a break.
  task automatic test_pass_clamping();
    set_passes(2'd0);
    send_point(make_pt(32'sd10, 32'sd20, 32'sd30), 1'b0);
    send_point(make_pt(-32'sd10, -32'sd20, -32'sd30), 1'b1);
    set_passes(2'd3);
    send_point(make_pt(32'sd100, 32'sd0, -32'sd100), 1'b0);
    send_point(make_pt(32'sd5, 32'sd5, 32'sd5), 1'b0);
    send_point(BREAK_PT, 1'b1);
    wait_until_drained();
  endtask

  // The pass count changes inside an open trail: the second pass sits idle
  // with its segment kept and picks it up again when it is switched back on.
  task automatic test_mid_trail_pass_change();
    set_passes(2'd2);
    send_point(make_pt(32'sd1000, 32'sd2000, 32'sd3000), 1'b0);
    send_point(make_pt(-32'sd400, 32'sd800, 32'sd12), 1'b0);
    set_passes(2'd1);
    send_point(make_pt(32'sd64, 32'sd64, 32'sd64), 1'b0);
    set_passes(2'd2);
    send_point(make_pt(32'sd1, 32'sd2, 32'sd3), 1'b1);
    wait_until_drained();
  endtask

  // The receiver holds off for a long stretch while points keep coming with
  // no gaps, so every stage fills and the input side has to stall.
  task automatic test_output_backpressure();
    set_passes(2'd2);
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    hold_req   = 1'b1;
    for (int i = 0; i < 14; i++)
      send_point(rand_pt(SPAN_FULL), i == 13);
    wait_until_drained();
  endtask

  // Mostly well-formed trails with random content: a few segments of one to
  // six points, each closed by a break or by the end of the trail. Now and
  // then a stray break or a bare end of trail is slipped in, the pass count
  // is rewritten and the idling on either side is switched on or off.
  task automatic test_random_trails(int n_items);
    int          stop_at;
    int          n_seg;
    int          len;
    bit          eot;
    bit          last_seg;
    coord_span_t span;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      if ($urandom_range(0, 2) == 0) set_passes(2'($urandom_range(0, 3)));
      tx_idle_en = $urandom_range(0, 2) != 0;
      rx_idle_en = $urandom_range(0, 2) != 0;
      n_seg = $urandom_range(1, 4);
      for (int s = 0; s < n_seg; s++) begin
        last_seg = (s == n_seg - 1);
        span     = coord_span_t'($urandom_range(0, 3) % 3);
        len      = $urandom_range(1, 6);
        eot      = 1'b0;
        for (int j = 0; j < len; j++) begin
          eot = last_seg && (j == len - 1) && ($urandom_range(0, 2) != 0);
          send_point(rand_pt(span), eot);
          if (!eot && $urandom_range(0, 19) == 0)
            send_point(BREAK_PT, 1'($urandom_range(0, 1)));
        end
        if (!eot) send_point(BREAK_PT, last_seg && $urandom_range(0, 1));
      end
    end
    wait_until_drained();
  endtask

  // --------------------------------------------------------------------------
  // Sequence of the run.
  // --------------------------------------------------------------------------
  initial begin : run_tests
    in_bus.valid        = 1'b0;
    in_bus.pos_x        = '0;
    in_bus.pos_y        = '0;
    in_bus.pos_z        = '0;
    in_bus.end_of_trail = 1'b0;
    cfg_wr_en           = 1'b0;
    cfg_wr_data         = 2'd0;
    passes_reg          = 2'd1;
    foreach (seg_len[k]) begin
      seg_len[k] = SEG_NONE;
      last_pt[k] = '0;
    end
    items_sent   = 0;
    error_count  = 0;
    tx_idle_en   = 1'b1;
    rx_idle_en   = 1'b1;
    hold_req     = 1'b0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_breaks_and_single_points();
    test_extremes_one_pass();
    test_two_pass_zero_cut();
    test_pass_clamping();
    test_mid_trail_pass_change();
    test_output_backpressure();
    test_random_trails(RANDOM_ITEMS);

    // wait_until_drained has already allowed for the latency; anything still
    // owed now will never come.
    if (expected_pts.size() != 0)
      report_mismatch($sformatf("%0d expected results never arrived", expected_pts.size()));

    $display("Run covered %0d input points and %0d smoothed points, with pass counts 0 to 3,",
             items_sent, results_seen);
    $display("random idling on both sides and one long output stall; %0d mismatches.",
             error_count);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== polyline_corner_cut_smoother_unit.f =====
sv/pcc_pkg.sv
sv/pcc_if.sv
sv/pcc_cell.sv
sv/pcc_collect.sv
sv/polyline_corner_cut_smoother_unit.sv
sim/polyline_corner_cut_smoother_unit_tb.sv
